### rtl/shmix_pkg.sv
// Shared types, constants and lane functions for the three-lane string hash.
`default_nettype none
package shmix_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CharW = 8;
  localparam int unsigned FillW = 2;

  localparam logic [WordW-1:0] SeedBase = 32'hdeadbeef;

  // Fill count at which the current group is full
  localparam logic [FillW-1:0] FillFull = 2'd3;

  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
  } lanes_t;

  // Lanes after absorbing the last character, and whether final must run
  typedef struct packed {
    lanes_t lanes;
    logic   do_final;
  } snap_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input int unsigned k);
    return (x << k) | (x >> (WordW - k));
  endfunction

  // Reversible mix of a full group into the lanes
  function automatic lanes_t lanes_mix(input lanes_t l);
    logic [WordW-1:0] a, b, c;
    lanes_t r;
    a = l.a; b = l.b; c = l.c;
    a = a - c; a = a ^ rotl(c, 4);  c = c + b;
    b = b - a; b = b ^ rotl(a, 6);  a = a + c;
    c = c - b; c = c ^ rotl(b, 8);  b = b + a;
    a = a - c; a = a ^ rotl(c, 16); c = c + b;
    b = b - a; b = b ^ rotl(a, 19); a = a + c;
    c = c - b; c = c ^ rotl(b, 4);  b = b + a;
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  // Final avalanche; only lane c is reported
  function automatic logic [WordW-1:0] lanes_final_c(input lanes_t l);
    logic [WordW-1:0] a, b, c;
    a = l.a; b = l.b; c = l.c;
    c = c ^ b; c = c - rotl(b, 14);
    a = a ^ c; a = a - rotl(c, 11);
    b = b ^ a; b = b - rotl(a, 25);
    c = c ^ b; c = c - rotl(b, 16);
    a = a ^ c; a = a - rotl(c, 4);
    b = b ^ a; b = b - rotl(a, 14);
    c = c ^ b; c = c - rotl(b, 24);
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/shmix_absorb.sv
// Lane state: seeding, group mixing and character absorption.
`default_nettype none
module shmix_absorb (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                take_i,
  input  wire logic signed [shmix_pkg::CharW-1:0]  ch_i,
  input  wire logic [shmix_pkg::WordW-1:0]         string_length_i,
  input  wire logic                                last_i,
  input  wire logic                                no_char_i,
  output shmix_pkg::snap_t                         snap_o
);

  shmix_pkg::lanes_t                  lanes_q, lanes_d;
  shmix_pkg::lanes_t                  base, mixed;
  logic [shmix_pkg::FillW-1:0]        fill_q, fill_d, fill_base, fill_new;
  logic                               in_string_q, in_string_d;
  logic [shmix_pkg::WordW-1:0]        seed, word;

  // Seed from the sampled length, sign-extended character word
  assign seed = shmix_pkg::SeedBase +
                {string_length_i[shmix_pkg::WordW-3:0], 2'b00};
  assign word = {{(shmix_pkg::WordW-shmix_pkg::CharW){ch_i[shmix_pkg::CharW-1]}}, ch_i};
  assign mixed = shmix_pkg::lanes_mix(base);

  // Absorb one transaction into the lanes
  always_comb begin
    if (in_string_q) begin
      base      = lanes_q;
      fill_base = fill_q;
    end else begin
      base.a    = seed;
      base.b    = seed;
      base.c    = seed;
      fill_base = '0;
    end
    lanes_d  = base;
    fill_new = fill_base;
    if (!no_char_i) begin
      unique case (fill_base)
        2'd0: begin
          lanes_d.a = base.a + word;
          fill_new  = 2'd1;
        end
        2'd1: begin
          lanes_d.b = base.b + word;
          fill_new  = 2'd2;
        end
        2'd2: begin
          lanes_d.c = base.c + word;
          fill_new  = shmix_pkg::FillFull;
        end
        default: begin
          // full group followed by another character: mix first
          lanes_d   = mixed;
          lanes_d.a = mixed.a + word;
          fill_new  = 2'd1;
        end
      endcase
    end
    fill_d      = last_i ? '0 : fill_new;
    in_string_d = !last_i;
  end

  assign snap_o.lanes    = lanes_d;
  assign snap_o.do_final = (fill_new != '0);

  // Control state and lane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      in_string_q <= 1'b0;
      lanes_q     <= '0;
    end else if (take_i) begin
      fill_q      <= fill_d;
      in_string_q <= in_string_d;
      lanes_q     <= lanes_d;
    end
  end

endmodule
`default_nettype wire

### rtl/shmix_final.sv
// Result path: snapshot register, final avalanche and output register.
`default_nettype none
module shmix_final (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire shmix_pkg::snap_t             snap_i,
  output logic                              free_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [shmix_pkg::WordW-1:0]       hash_o
);

  shmix_pkg::snap_t             snap_q;
  logic                         snap_valid_q, snap_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic [shmix_pkg::WordW-1:0]  hash_q, hash_d;
  logic                         out_free, snap_adv;

  // Stage movement
  assign out_free     = !out_valid_q || out_ready_i;
  assign snap_adv     = snap_valid_q && out_free;
  assign free_o       = !snap_valid_q || out_free;
  assign snap_valid_d = load_i || (snap_valid_q && !snap_adv);
  assign out_valid_d  = snap_adv || (out_valid_q && !out_ready_i);
  assign hash_d       = snap_q.do_final ? shmix_pkg::lanes_final_c(snap_q.lanes)
                                        : snap_q.lanes.c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      snap_q <= snap_i;
    end
    if (snap_adv) begin
      hash_q <= hash_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_o      = hash_q;

endmodule
`default_nettype wire

### rtl/string_hash_three_lane_mix.sv
// Top level of the streaming three-lane string hash.
// Throughput: one character transaction per cycle, sustained while input ready is high.
// Result path: after the last character is taken, the hash passes through the
//   snapshot register and then the final-avalanche output register.
// Input ready falls only while both of those registers hold untaken results.
// Reset (asynchronous, active low) clears the string state and drops all valids.
`default_nettype none
module string_hash_three_lane_mix (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [shmix_pkg::CharW-1:0]  ch_i,
  input  wire logic [shmix_pkg::WordW-1:0]         string_length_i,
  input  wire logic                                last_i,
  input  wire logic                                no_char_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [shmix_pkg::WordW-1:0]              hash_o
);

  logic             take, free;
  shmix_pkg::snap_t snap;

  assign in_ready_o = free;
  assign take       = in_valid_i && free;

  shmix_absorb u_absorb (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .ch_i            (ch_i),
    .string_length_i (string_length_i),
    .last_i          (last_i),
    .no_char_i       (no_char_i),
    .snap_o          (snap)
  );

  shmix_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take && last_i),
    .snap_i      (snap),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_o      (hash_o)
  );

  // Back-pressure only while a result is held at the output
  a_ready_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a held result");

  // A string-ending transaction is always followed by a valid output, after the snapshot and output registers
  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i) |=> ##1 out_valid_o)
    else $error("no result after the last character");

endmodule
`default_nettype wire

### sim/string_hash_three_lane_mix_test.sv
// Self-checking testbench for the streaming three-lane string hash.
module string_hash_three_lane_mix_test;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic signed [shmix_pkg::CharW-1:0] ch_i;
  logic [shmix_pkg::WordW-1:0]        string_length_i;
  logic                               last_i;
  logic                               no_char_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic [shmix_pkg::WordW-1:0]        hash_o;

  string_hash_three_lane_mix dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .ch_i            (ch_i),
    .string_length_i (string_length_i),
    .last_i          (last_i),
    .no_char_i       (no_char_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hash_o          (hash_o)
  );

  always #10 clk_i = ~clk_i;

  // One row of the directed stimulus; typed_hash is used only when has_typed is set
  typedef struct packed {
    logic [7:0]                  ch;
    logic [shmix_pkg::WordW-1:0] len;
    logic                        lst;
    logic                        nc;
    logic                        has_typed;
    logic [shmix_pkg::WordW-1:0] typed_hash;
  } stim_row_t;

  localparam int NumRows = 21;
  localparam int RandomItems = 1300;

  stim_row_t stim_table [0:NumRows-1] = '{
    // empty strings: the hash is just the seed
    '{8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b1, 32'hdeadbeef},
    '{8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 32'hdeadbeeb},
    '{8'h5a, 32'h0000_0001, 1'b1, 1'b1, 1'b1, 32'hdeadbef3},
    // single extreme characters
    '{8'h80, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h7f, 32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0},
    // exactly one full group, so final without mix
    '{8'hff, 32'h0000_0003, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h00, 32'h0000_0003, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h01, 32'h0000_0003, 1'b1, 1'b0, 1'b0, 32'h0},
    // four characters: mix, then a one-character tail
    '{8'h41, 32'h0000_0004, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h42, 32'h0000_0004, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h43, 32'h0000_0004, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h44, 32'h0000_0004, 1'b1, 1'b0, 1'b0, 32'h0},
    // opened by an empty item, characters follow
    '{8'hc3, 32'h0000_0002, 1'b0, 1'b1, 1'b0, 32'h0},
    '{8'h61, 32'h0000_0002, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h62, 32'h0000_0002, 1'b1, 1'b0, 1'b0, 32'h0},
    // closed by an empty item after one character
    '{8'h78, 32'h0000_0005, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h00, 32'h0000_0005, 1'b1, 1'b1, 1'b0, 32'h0},
    // declared length disagrees with the characters sent
    '{8'haa, 32'hffff_ffff, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'h55, 32'hffff_ffff, 1'b1, 1'b0, 1'b0, 32'h0},
    // opened and closed by empty items: seed reported as is
    '{8'h3c, 32'h0000_0007, 1'b0, 1'b1, 1'b0, 32'h0},
    '{8'hc3, 32'h0000_0007, 1'b1, 1'b1, 1'b1, 32'hdeadbf0b}
  };

  // Hash predictor state
  shmix_pkg::lanes_t           pred_lanes;
  logic [shmix_pkg::FillW-1:0] pred_fill;
  bit                          pred_open;

  logic [shmix_pkg::WordW-1:0] pending_hashes [$];
  int               errors;
  int               items_sent;
  int               hashes_seen;
  int               strings_sent;
  int               send_idle_pct;
  int               recv_idle_pct;
  int               hold_left;

  function automatic logic [shmix_pkg::WordW-1:0] rot_left(
      input logic [shmix_pkg::WordW-1:0] x, input int k);
    return (x << k) | (x >> (shmix_pkg::WordW - k));
  endfunction

  function automatic shmix_pkg::lanes_t mix_lanes(input shmix_pkg::lanes_t l);
    logic [shmix_pkg::WordW-1:0] a, b, c;
    shmix_pkg::lanes_t r;
    a = l.a; b = l.b; c = l.c;
    a -= c; a ^= rot_left(c, 4);  c += b;
    b -= a; b ^= rot_left(a, 6);  a += c;
    c -= b; c ^= rot_left(b, 8);  b += a;
    a -= c; a ^= rot_left(c, 16); c += b;
    b -= a; b ^= rot_left(a, 19); a += c;
    c -= b; c ^= rot_left(b, 4);  b += a;
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  function automatic shmix_pkg::lanes_t avalanche_lanes(input shmix_pkg::lanes_t l);
    logic [shmix_pkg::WordW-1:0] a, b, c;
    shmix_pkg::lanes_t r;
    a = l.a; b = l.b; c = l.c;
    c ^= b; c -= rot_left(b, 14);
    a ^= c; a -= rot_left(c, 11);
    b ^= a; b -= rot_left(a, 25);
    c ^= b; c -= rot_left(b, 16);
    a ^= c; a -= rot_left(c, 4);
    b ^= a; b -= rot_left(a, 14);
    c ^= b; c -= rot_left(b, 24);
    r.a = a; r.b = b; r.c = c;
    return r;
  endfunction

  // Absorb one accepted character transaction; got_hash set when a string ends
  task automatic absorb_char(input logic [7:0] ch, input logic [shmix_pkg::WordW-1:0] len,
                             input bit lst, input bit nc,
                             output bit got_hash,
                             output logic [shmix_pkg::WordW-1:0] hash);
    logic [shmix_pkg::WordW-1:0] word;
    logic [shmix_pkg::WordW-1:0] seed;
    word = {{(shmix_pkg::WordW-8){ch[7]}}, ch};
    got_hash = 1'b0;
    hash = '0;
    if (!pred_open) begin
      seed = shmix_pkg::SeedBase + (len << 2);
      pred_lanes.a = seed;
      pred_lanes.b = seed;
      pred_lanes.c = seed;
      pred_fill = '0;
      pred_open = 1'b1;
    end
    if (!nc) begin
      if (pred_fill == 2'd3) begin
        pred_lanes = mix_lanes(pred_lanes);
        pred_fill = '0;
      end
      case (pred_fill)
        2'd0: pred_lanes.a += word;
        2'd1: pred_lanes.b += word;
        default: pred_lanes.c += word;
      endcase
      pred_fill++;
    end
    if (lst) begin
      if (pred_fill != 0) pred_lanes = avalanche_lanes(pred_lanes);
      hash = pred_lanes.c;
      got_hash = 1'b1;
      pred_fill = '0;
      pred_open = 1'b0;
    end
  endtask

  // Offer one transaction, wait for it to be taken, then predict
  task automatic offer_char(input logic [7:0] ch, input logic [shmix_pkg::WordW-1:0] len,
                            input bit lst, input bit nc,
                            input bit has_typed,
                            input logic [shmix_pkg::WordW-1:0] typed_hash);
    bit                          got_hash;
    logic [shmix_pkg::WordW-1:0] hash;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    ch_i            <= ch;
    string_length_i <= len;
    last_i          <= lst;
    no_char_i       <= nc;
    do @(posedge clk_i); while (!in_ready_o);
    absorb_char(ch, len, lst, nc, got_hash, hash);
    if (got_hash) begin
      pending_hashes.push_back(has_typed ? typed_hash : hash);
      strings_sent++;
    end
    items_sent++;
  endtask

  // One string with random content; mostly well formed, some with empty items
  // or a declared length that disagrees
  task automatic offer_random_string(input int n);
    logic [shmix_pkg::WordW-1:0] len;
    int               style;
    int               gap_at;
    len = ($urandom_range(9) == 0) ? $urandom() : n;
    style = $urandom_range(9);
    if (n == 0) begin
      if (style < 3) offer_char(8'($urandom_range(255)), len, 1'b0, 1'b1, 1'b0, '0);
      offer_char(8'($urandom_range(255)), len, 1'b1, 1'b1, 1'b0, '0);
    end else begin
      gap_at = (style == 0) ? $urandom_range(n) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == gap_at) offer_char(8'($urandom_range(255)), len, 1'b0, 1'b1, 1'b0, '0);
        offer_char(8'($urandom_range(255)), len, (i == n-1) && (gap_at != n), 1'b0,
                   1'b0, '0);
      end
      if (gap_at == n) offer_char(8'($urandom_range(255)), len, 1'b1, 1'b1, 1'b0, '0);
    end
  endtask

  task automatic wait_for_drain();
    while (pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random back-pressure, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each hash transaction against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      hashes_seen++;
      if (pending_hashes.size() == 0) begin
        $error("hash: unexpected result %h", hash_o);
        errors++;
      end else if (hash_o !== pending_hashes[0]) begin
        $error("hash: expected %h, got %h", pending_hashes[0], hash_o);
        errors++;
        void'(pending_hashes.pop_front());
      end else begin
        void'(pending_hashes.pop_front());
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("string_hash_three_lane_mix test failed");
    $finish;
  end

  initial begin
    int n;
    errors = 0;
    items_sent = 0;
    hashes_seen = 0;
    strings_sent = 0;
    hold_left = 0;
    pred_lanes = '0;
    pred_fill = '0;
    pred_open = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 56;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    ch_i            <= '0;
    string_length_i <= '0;
    last_i          <= 1'b0;
    no_char_i       <= 1'b0;
    out_ready_i     <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    for (int r = 0; r < NumRows; r++) begin
      offer_char(stim_table[r].ch, stim_table[r].len, stim_table[r].lst, stim_table[r].nc,
                 stim_table[r].has_typed, stim_table[r].typed_hash);
    end

    // Random strings: sender idles less than receiver, then the reverse
    while (items_sent < NumRows + RandomItems / 3) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      offer_random_string(n);
    end
    send_idle_pct = 56;
    recv_idle_pct = 31;
    while (items_sent < NumRows + 2 * RandomItems / 3) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      offer_random_string(n);
    end

    // Sender pauses until all hashes are back, then no idling at all
    in_valid_i <= 1'b0;
    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // Long receiver hold-off while short strings keep coming, to fill the block
    hold_left = 60;
    for (int k = 0; k < 24; k++) offer_random_string($urandom_range(1, 2));

    while (items_sent < NumRows + RandomItems) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      offer_random_string(n);
    end
    in_valid_i <= 1'b0;

    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (pending_hashes.size() != 0) begin
      $error("hash: %0d expected results never arrived", pending_hashes.size());
      errors++;
    end

    $display("Sent %0d character transactions in %0d strings; %0d hashes compared.",
             items_sent, strings_sent, hashes_seen);
    $display("Covered empty, open-ended and mismatched-length strings under back-pressure.");
    if (errors == 0) begin
      $display("string_hash_three_lane_mix test passed");
    end else begin
      $display("string_hash_three_lane_mix test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/shmix_pkg.sv
rtl/shmix_absorb.sv
rtl/shmix_final.sv
rtl/string_hash_three_lane_mix.sv
sim/string_hash_three_lane_mix_test.sv
